// ===== rtl/flpt_pkg.sv =====
package flpt_pkg;

    localparam int IDX_W   = 9;
    localparam int VPN_W   = 36;
    localparam int PPN_W   = 40;
    localparam int CNT_W   = 21;
    localparam int ENTRY_W = 64;
    localparam int STAT_W  = 2;
    localparam int LVL_W   = 2;

    localparam logic [IDX_W-1:0] IDX_LAST = '1;
    localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NORES  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    localparam logic CMD_MAP    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // flag bits of a table entry
    localparam logic [11:0] PTE_FLAGS = 12'h003;  // RW | P

    // build a present entry from a physical page number
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [PPN_W-1:0] ppn);
        make_entry = {12'd0, ppn, PTE_FLAGS};
    endfunction

    // 9-bit table index of one level, level 0 is the root
    function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                     input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                2'd0:    idx = vpn[35:27];
                2'd1:    idx = vpn[26:18];
                2'd2:    idx = vpn[17:9];
                default: idx = vpn[8:0];
            endcase
            level_index = idx;
        end
    endfunction

endpackage

// ===== rtl/flpt_ram.sv =====
module flpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/flpt_ptr_unit.sv =====
// Decodes a directory entry: present bit and pool page it points to.
module flpt_ptr_unit
    import flpt_pkg::*;
#(
    parameter int PW  = 6,
    parameter int NFW = 7
) (
    input  logic [ENTRY_W-1:0] entry,
    input  logic [PPN_W-1:0]   base,
    input  logic [NFW-1:0]     next_free,
    output logic               present,
    output logic               in_pool,
    output logic [PW-1:0]      page
);

    logic [PPN_W-1:0] phys;
    logic [PPN_W-1:0] k;

    assign phys    = {4'd0, entry[47:12]};
    assign k       = phys - base;
    assign present = entry[0];
    // next_free never exceeds the pool size, so this also bounds the pool
    assign in_pool = k < {{(PPN_W-NFW){1'b0}}, next_free};
    assign page    = k[PW-1:0];

endmodule

// ===== rtl/four_level_page_table_mapper.sv =====
// Four-level page table builder, 4 KiB pages, tables held in an on-chip
// RAM of POOL_PAGES x 512 entries, pool page 0 being the root. After reset the
// root table is zeroed before the first request is taken. Each level costs one
// registered RAM read; a new table page is swept to zero one entry a cycle
// through the single RAM port before it is linked in. One request is in work at
// a time; the result sits in an output register so the next request can be
// taken while it waits.
module four_level_page_table_mapper
    import flpt_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [39:0]   cfg_data,    // pool_base_page
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,     // virt_page[35:0], phys_page[75:36], page_count[96:76]
    input  logic          s_tuser,     // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata      // status[1:0], leaf_entry[65:2]
);

    localparam int PW  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int NFW = $clog2(POOL_PAGES + 1);
    localparam int AW  = PW + IDX_W;
    localparam logic [NFW-1:0] POOL_LIMIT = NFW'(POOL_PAGES);

    typedef enum logic [2:0] {
        S_ZERO, S_IDLE, S_START, S_READ, S_EVAL, S_LINK, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               boot_reg, boot_next;
    logic [PPN_W-1:0]   base_reg;
    logic               cmd_reg, cmd_next;
    logic [VPN_W-1:0]   vp_reg, vp_next;
    logic [PPN_W-1:0]   pp_reg, pp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [PW-1:0]      page_reg, page_next;
    logic [PW-1:0]      alloc_reg, alloc_next;
    logic [NFW-1:0]     nfree_reg, nfree_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [ENTRY_W-1:0] leaf_reg, leaf_next;
    logic               mvalid_reg, mvalid_next;
    logic [STAT_W-1:0]  mstat_reg, mstat_next;
    logic [ENTRY_W-1:0] mleaf_reg, mleaf_next;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic               e_present, e_in_pool;
    logic [PW-1:0]      e_page;
    logic [IDX_W-1:0]   cur_idx;

    assign cur_idx = level_index(vp_reg, lvl_reg);

    flpt_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_PAGES * 512)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    flpt_ptr_unit #(.PW(PW), .NFW(NFW)) u_ptr (
        .entry     (ram_rdata),
        .base      (base_reg),
        .next_free (nfree_reg),
        .present   (e_present),
        .in_pool   (e_in_pool),
        .page      (e_page)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {6'd0, mleaf_reg, mstat_reg};

    always_comb
    begin
        state_next  = state_reg;
        boot_next   = boot_reg;
        cmd_next    = cmd_reg;
        vp_next     = vp_reg;
        pp_next     = pp_reg;
        cnt_next    = cnt_reg;
        lvl_next    = lvl_reg;
        page_next   = page_reg;
        alloc_next  = alloc_reg;
        nfree_next  = nfree_reg;
        clr_next    = clr_reg;
        stat_next   = stat_reg;
        leaf_next   = leaf_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        mstat_next  = mstat_reg;
        mleaf_next  = mleaf_reg;
        ram_we      = 1'b0;
        ram_addr    = {page_reg, cur_idx};
        ram_wdata   = make_entry(pp_reg);

        unique case (state_reg)
            S_ZERO:
            begin
                ram_we    = 1'b1;
                ram_addr  = {alloc_reg, clr_reg};
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_LAST)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_LINK;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    vp_next    = s_tdata[35:0];
                    pp_next    = s_tdata[75:36];
                    cnt_next   = s_tdata[96:76];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                stat_next = ST_OK;
                leaf_next = '0;
                lvl_next  = '0;
                page_next = '0;
                if (cmd_reg == CMD_MAP && cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (lvl_reg == LVL_LEAF)
                begin
                    if (e_present)
                    begin
                        if (cmd_reg == CMD_LOOKUP)
                        begin
                            leaf_next = ram_rdata;
                        end
                        else
                        begin
                            stat_next = ST_DUP;
                        end
                        state_next = S_DONE;
                    end
                    else if (cmd_reg == CMD_LOOKUP)
                    begin
                        stat_next  = ST_ABSENT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        vp_next  = vp_reg + 1'b1;
                        pp_next  = pp_reg + 1'b1;
                        cnt_next = cnt_reg - 1'b1;
                        lvl_next  = '0;
                        page_next = '0;
                        state_next = (cnt_reg == CNT_W'(1)) ? S_DONE : S_READ;
                    end
                end
                else if (e_present)
                begin
                    if (e_in_pool)
                    begin
                        page_next  = e_page;
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        stat_next  = (cmd_reg == CMD_LOOKUP) ? ST_ABSENT : ST_NORES;
                        state_next = S_DONE;
                    end
                end
                else if (cmd_reg == CMD_LOOKUP)
                begin
                    stat_next  = ST_ABSENT;
                    state_next = S_DONE;
                end
                else if (nfree_reg >= POOL_LIMIT)
                begin
                    stat_next  = ST_NORES;
                    state_next = S_DONE;
                end
                else
                begin
                    alloc_next = nfree_reg[PW-1:0];
                    nfree_next = nfree_reg + 1'b1;
                    clr_next   = '0;
                    state_next = S_ZERO;
                end
            end
            S_LINK:
            begin
                ram_we     = 1'b1;
                ram_wdata  = make_entry(base_reg + {{(PPN_W-PW){1'b0}}, alloc_reg});
                page_next  = alloc_reg;
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mstat_next  = stat_reg;
                    mleaf_next  = leaf_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_ZERO;
            boot_reg   <= 1'b1;
            alloc_reg  <= '0;
            clr_reg    <= '0;
            nfree_reg  <= NFW'(1);
            base_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            boot_reg   <= boot_next;
            alloc_reg  <= alloc_next;
            clr_reg    <= clr_next;
            nfree_reg  <= nfree_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        vp_reg    <= vp_next;
        pp_reg    <= pp_next;
        cnt_reg   <= cnt_next;
        lvl_reg   <= lvl_next;
        page_reg  <= page_next;
        stat_reg  <= stat_next;
        leaf_reg  <= leaf_next;
        mstat_reg <= mstat_next;
        mleaf_reg <= mleaf_next;
    end

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfree_reg <= POOL_LIMIT)
        else $error("allocator past pool end");

    a_pool_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 nfree_reg >= $past(nfree_reg))
        else $error("allocator moved backwards");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    a_fail_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[65:2] == '0))
        else $error("leaf entry on failed request");

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import flpt_pkg::*;

    localparam int POOL       = 64;
    localparam int ENTRIES    = 512;
    localparam int IDLE_LIMIT = 30000;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] leaf;
    } walk_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [PPN_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [103:0]       s_tdata;     // virt_page[35:0], phys_page[75:36], page_count[96:76]
    logic               s_tuser;     // command
    logic               m_tvalid;
    logic               m_tready;
    logic [71:0]        m_tdata;     // status[1:0], leaf_entry[65:2]

    // shadow copy of the table store and allocator
    logic [ENTRY_W-1:0] shadow_tables [int];
    int                 shadow_next_free;
    logic [PPN_W-1:0]   shadow_pool_base;

    walk_result_t       pending_results [$];
    int                 error_count;
    int                 result_count;
    int                 map_count;
    int                 lookup_count;
    int                 idle_cycles;
    int                 ready_hold;
    int                 ready_gap;
    bit                 no_idle;
    logic [VPN_W-1:0]   hot_pages [8];

    four_level_page_table_mapper #(.POOL_PAGES(POOL)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [ENTRY_W-1:0] table_read(input int slot_addr);
        return shadow_tables.exists(slot_addr) ? shadow_tables[slot_addr] : '0;
    endfunction

    // follow or create the child table behind one directory slot
    function automatic logic [STAT_W-1:0] table_descend(input int page,
                                                        input logic [IDX_W-1:0] idx,
                                                        input bit alloc,
                                                        output int child);
        int               slot_addr;
        logic [ENTRY_W-1:0] entry;
        logic [PPN_W-1:0] pool_off;
        slot_addr = page * ENTRIES + int'(idx);
        entry = table_read(slot_addr);
        child = 0;
        if (!entry[0])
        begin
            if (!alloc)
                return ST_ABSENT;
            if (shadow_next_free >= POOL)
                return ST_NORES;
            child = shadow_next_free;
            shadow_next_free++;
            for (int i = 0; i < ENTRIES; i++)
                shadow_tables.delete(child * ENTRIES + i);
            shadow_tables[slot_addr] = {12'd0, shadow_pool_base + PPN_W'(child), 12'h003};
            return ST_OK;
        end
        // directory address field covers bits 47:12 only
        pool_off = {4'd0, entry[47:12]} - shadow_pool_base;
        if (pool_off >= PPN_W'(shadow_next_free) || pool_off >= PPN_W'(POOL))
            return alloc ? ST_NORES : ST_ABSENT;
        child = int'(pool_off);
        return ST_OK;
    endfunction

    function automatic logic [STAT_W-1:0] table_walk(input logic [VPN_W-1:0] vpn,
                                                     input bit alloc,
                                                     output int leaf_page);
        logic [STAT_W-1:0] st;
        int                page;
        page = 0;
        leaf_page = 0;
        st = table_descend(page, vpn[35:27], alloc, page);
        if (st != ST_OK)
            return st;
        st = table_descend(page, vpn[26:18], alloc, page);
        if (st != ST_OK)
            return st;
        st = table_descend(page, vpn[17:9], alloc, page);
        leaf_page = page;
        return st;
    endfunction

    function automatic walk_result_t translate_request(input logic cmd,
                                                       input logic [VPN_W-1:0] vpn,
                                                       input logic [PPN_W-1:0] ppn,
                                                       input logic [CNT_W-1:0] cnt);
        walk_result_t res;
        int           leaf_page;
        int           slot_addr;
        res.status = ST_OK;
        res.leaf = '0;
        if (cmd == CMD_LOOKUP)
        begin
            res.status = table_walk(vpn, 1'b0, leaf_page);
            if (res.status == ST_OK)
            begin
                res.leaf = table_read(leaf_page * ENTRIES + int'(vpn[8:0]));
                if (!res.leaf[0])
                begin
                    res.leaf = '0;
                    res.status = ST_ABSENT;
                end
            end
        end
        else
        begin
            for (int i = 0; i < int'(cnt); i++)
            begin
                res.status = table_walk(vpn, 1'b1, leaf_page);
                if (res.status != ST_OK)
                    break;
                slot_addr = leaf_page * ENTRIES + int'(vpn[8:0]);
                if (table_read(slot_addr) & 64'd1)
                begin
                    res.status = ST_DUP;
                    break;
                end
                shadow_tables[slot_addr] = {12'd0, ppn, 12'h003};
                vpn = vpn + 1'b1;
                ppn = ppn + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic bit page_is_mapped(input logic [VPN_W-1:0] vpn);
        int leaf_page;
        if (table_walk(vpn, 1'b0, leaf_page) != ST_OK)
            return 1'b0;
        return (table_read(leaf_page * ENTRIES + int'(vpn[8:0])) & 64'd1) != 64'd0;
    endfunction

    function automatic int sender_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_request(input logic cmd, input logic [VPN_W-1:0] vpn,
                                input logic [PPN_W-1:0] ppn, input logic [CNT_W-1:0] cnt);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {7'd0, cnt, ppn, vpn};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(translate_request(cmd, vpn, ppn, cnt));
        if (cmd == CMD_LOOKUP)
            lookup_count++;
        else
            map_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_pool_base(input logic [PPN_W-1:0] base);
        wait_drained();
        repeat (12) @(negedge clk);
        cfg_data  = base;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_pool_base = base;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_requests(input int n);
        logic [VPN_W-1:0] vpn;
        logic [CNT_W-1:0] cnt;
        int               r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                vpn = hot_pages[$urandom_range(0, 7)] + VPN_W'($urandom_range(0, 700));
            else
                vpn = VPN_W'({$urandom, $urandom});
            r = $urandom_range(0, 99);
            if (r < 4 && page_is_mapped(vpn))
                cnt = CNT_W'($urandom_range(1, 1048576));   // stops at once as a duplicate
            else if (r < 10)
                cnt = '0;
            else if (r < 14)
                cnt = CNT_W'($urandom_range(17, 64));
            else
                cnt = CNT_W'($urandom_range(1, 16));
            send_request(1'($urandom_range(0, 1)), vpn,
                         PPN_W'({$urandom, $urandom}), cnt);
        end
    endtask

    task automatic test_empty_tables();
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_LOOKUP, '1, '1, '1);
        send_request(CMD_MAP, 36'h000000100, 40'h1, '0);      // zero count
        send_request(CMD_LOOKUP, 36'h000000100, '0, '0);
    endtask

    task automatic test_map_and_lookup();
        send_request(CMD_MAP, 36'h000000100, 40'hab_cdef_0123, 21'd3);
        send_request(CMD_LOOKUP, 36'h000000101, '0, '0);
        send_request(CMD_LOOKUP, 36'h000000103, '0, '0);
        send_request(CMD_MAP, 36'h0000001fe, 40'h0, 21'd4);    // crosses a leaf table
        send_request(CMD_LOOKUP, 36'h000000201, '0, '0);
        // wraps in both the virtual and physical page numbers
        send_request(CMD_MAP, 36'hfffffffff, 40'hff_ffff_ffff, 21'd2);
        send_request(CMD_LOOKUP, 36'hfffffffff, '0, '0);
        send_request(CMD_LOOKUP, 36'h000000000, '0, '0);
        send_request(CMD_MAP, 36'h000000102, 40'h5, 21'd1_048_576);  // already mapped
        send_request(CMD_MAP, 36'h0000000fe, 40'h77, 21'd4);   // partial run, then duplicate
        send_request(CMD_LOOKUP, 36'h0000000ff, '0, '0);
        send_request(CMD_LOOKUP, 36'h5a5a5a5a5, '0, '0);
        wait_drained();
    endtask

    task automatic test_foreign_pointers();
        write_pool_base('1);
        send_request(CMD_LOOKUP, 36'h000000101, '0, '0);       // old tables look foreign
        send_request(CMD_MAP, 36'h000000105, 40'h9, 21'd1);
        send_request(CMD_MAP, 36'h800000000, 40'h3, 21'd2);    // new tables wrap the base
        send_request(CMD_LOOKUP, 36'h800000001, '0, '0);
        write_pool_base(40'h00_0001_2345);
        send_request(CMD_LOOKUP, 36'h800000001, '0, '0);
        send_request(CMD_MAP, 36'h800000004, 40'h3, 21'd1);
        send_request(CMD_LOOKUP, 36'h000000101, '0, '0);
        wait_drained();
    endtask

    task automatic test_output_stall();
        ready_hold = 2500;
        no_idle = 1'b1;
        for (int i = 0; i < 8; i++)
            send_request(i[0] ? CMD_LOOKUP : CMD_MAP, hot_pages[i] + 36'd900,
                         PPN_W'({$urandom, $urandom}), 21'd2);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_pool_exhaustion();
        for (int i = 0; i < 24; i++)
            send_request(CMD_MAP, {9'(100 + i), 27'h1234567},
                         PPN_W'({$urandom, $urandom}), 21'd2);
        send_request(CMD_LOOKUP, {9'd120, 27'h1234568}, '0, '0);
        wait_drained();
    endtask

    // checks each result against the oldest expectation
    always @(posedge clk)
    begin
        walk_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d leaf=%h", $time,
                         m_tdata[1:0], m_tdata[65:2]);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[1:0] !== exp_res.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             exp_res.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[65:2] !== exp_res.leaf)
                begin
                    $display("%0t: leaf mismatch expected %h actual %h", $time,
                             exp_res.leaf, m_tdata[65:2]);
                    error_count++;
                end
            end
        end
    end

    // receiver side: random short and occasional long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            ready_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_MAP;
        error_count = 0;
        result_count = 0;
        map_count = 0;
        lookup_count = 0;
        idle_cycles = 0;
        ready_hold = 0;
        ready_gap = 0;
        no_idle = 1'b0;
        shadow_next_free = 1;
        shadow_pool_base = '0;
        foreach (hot_pages[i])
            hot_pages[i] = VPN_W'({$urandom, $urandom});
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_tables();
        write_pool_base(40'h00_0001_2345);
        test_map_and_lookup();
        test_foreign_pointers();
        random_requests(1100);
        test_output_stall();
        test_pool_exhaustion();
        random_requests(150);
        write_pool_base('0);
        random_requests(50);
        write_pool_base(40'h00_0001_2345);
        random_requests(100);
        wait_drained();
        repeat (40) @(negedge clk);

        $display("Covered %0d map and %0d lookup requests, %0d results checked,",
                 map_count, lookup_count, result_count);
        $display("%0d of %0d table pages allocated, pool base rewritten across extremes",
                 shadow_next_free, POOL);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== four_level_page_table_mapper.f =====
rtl/flpt_pkg.sv
rtl/flpt_ram.sv
rtl/flpt_ptr_unit.sv
rtl/four_level_page_table_mapper.sv
dv/testbench.sv
